FILE: hdl/sctt_pkg.sv
// ----------------------------------------------------------------------------
// sctt_pkg: shared types and constants for counts-to-temperature/throttle
// Item formats, configuration layout, register indexes and the coolant table.
// ----------------------------------------------------------------------------
package sctt_pkg;

  // converter and sensor scaling
  localparam int COUNT_BITS   = 12;
  localparam int MV_FULL      = 3300;
  localparam int MV_W         = 12;
  localparam int SENS_W       = 14;
  localparam int SENS_MAX     = 16383;
  localparam int TEMP_W       = 8;
  localparam int PCT_W        = 7;
  localparam int PCT_FULL     = 100;

  // queue depths
  localparam int QDEPTH       = 4;
  localparam int ODEPTH       = 32;

  // coolant table, millivolts falling
  localparam int TABLE_POINTS = 8;
  localparam logic [SENS_W-1:0] TBL_MV [TABLE_POINTS] = '{
    14'd4400, 14'd3600, 14'd2700, 14'd1700, 14'd1000, 14'd600, 14'd500, 14'd300
  };
  localparam logic signed [TEMP_W-1:0] TBL_TEMP [TABLE_POINTS] = '{
    -8'sd20, 8'sd0, 8'sd20, 8'sd40, 8'sd60, 8'sd80, 8'sd100, 8'sd120
  };

  // configuration register indexes
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_NUM    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_DEN    = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THR_CLOSED = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THR_OPEN   = 8'd3;
  localparam int CFG_DATA_W = 16;

  typedef struct packed {
    logic [7:0]        div_num;
    logic [7:0]        div_den;
    logic [SENS_W-1:0] thr_closed;
    logic [SENS_W-1:0] thr_open;
  } cfg_regs_t;

  typedef struct packed {
    logic [COUNT_BITS-1:0] coolant_count;
    logic [COUNT_BITS-1:0] throttle_count;
  } in_item_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] coolant_celsius;
    logic [PCT_W-1:0]         throttle_percent;
    logic [MV_W-1:0]          coolant_adc_mv;
    logic [MV_W-1:0]          throttle_adc_mv;
  } out_item_t;

  typedef struct packed {
    logic [MV_W-1:0] cmv;
    logic [MV_W-1:0] tmv;
  } mv_pair_t;

endpackage

FILE: hdl/sensor_counts_to_temp_and_throttle.sv
// Throughput: one request per cycle while the output fifo has room; the
// 20-stage ratio dividers and the 8-stage interpolation dividers are fully
// pipelined, one quotient bit a stage. Results wait in a 32-entry output
// fifo that also bounds requests in flight. Reset (synchronous, rst high)
// empties all queues and loads ratio 1/1, closed 0 mV and open 2250 mV.
// ----------------------------------------------------------------------------
// sensor_counts_to_temp_and_throttle: top level
// Configuration registers, intake front, millivolt queue and compute back.
// ----------------------------------------------------------------------------
module sensor_counts_to_temp_and_throttle (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  sctt_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output sctt_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [sctt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sctt_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sctt_pkg::*;

  localparam int QCW = $clog2(QDEPTH + 1);

  cfg_regs_t      cfg;
  logic           q_push;
  logic           q_pop;
  mv_pair_t       q_wdata;
  mv_pair_t       q_rdata;
  logic [QCW-1:0] q_count;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.div_num    <= 8'd1;
      cfg.div_den    <= 8'd1;
      cfg.thr_closed <= '0;
      cfg.thr_open   <= SENS_W'(2250);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_DIV_NUM:    cfg.div_num    <= cfg_data[7:0];
        REG_DIV_DEN:    cfg.div_den    <= cfg_data[7:0];
        REG_THR_CLOSED: cfg.thr_closed <= cfg_data[SENS_W-1:0];
        REG_THR_OPEN:   cfg.thr_open   <= cfg_data[SENS_W-1:0];
        default: ;
      endcase
    end
  end

  sctt_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .in_data(in_data), .q_count(q_count), .q_push(q_push), .q_wdata(q_wdata)
  );

  // millivolt queue between front and back
  sctt_fifo #(.W($bits(mv_pair_t)), .DEPTH(QDEPTH)) u_queue (
    .clk(clk), .rst(rst), .push(q_push), .wdata(q_wdata),
    .pop(q_pop), .rdata(q_rdata), .count(q_count)
  );

  sctt_back u_back (
    .clk(clk), .rst(rst), .cfg(cfg), .q_count(q_count), .q_rdata(q_rdata),
    .q_pop(q_pop), .out_valid(out_valid), .out_ready(out_ready),
    .out_data(out_data)
  );
endmodule

FILE: hdl/sctt_fifo.sv
// ----------------------------------------------------------------------------
// sctt_fifo: small synchronous fifo
// Register array with read/write pointers and an occupancy count.
// ----------------------------------------------------------------------------
module sctt_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  logic [W-1:0]               wdata,
  input  logic                       pop,
  output logic [W-1:0]               rdata,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  assign rdata = mem[rd_ptr];

  // pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + ($clog2(DEPTH+1))'(push) - ($clog2(DEPTH+1))'(pop);
    end
  end
endmodule

FILE: hdl/sctt_div.sv
// ----------------------------------------------------------------------------
// sctt_div: pipelined restoring divider
// One quotient bit per stage, sideband data travels alongside.
// ----------------------------------------------------------------------------
module sctt_div #(
  parameter int NW = 20,
  parameter int DW = 8,
  parameter int QW = 8,
  parameter int SW = 1
) (
  input  logic          clk,
  input  logic [NW-1:0] num_in,
  input  logic [DW-1:0] den_in,
  input  logic [SW-1:0] side_in,
  output logic [QW-1:0] quo_out,
  output logic [SW-1:0] side_out
);
  localparam int XW = NW + QW;

  logic [NW-1:0] rem_r  [QW-1];
  logic [DW-1:0] den_r  [QW-1];
  logic [QW-1:0] quo_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int SH = QW - 1 - k;
    logic [NW-1:0] rem_i;
    logic [DW-1:0] den_i;
    logic [QW-1:0] quo_i;
    logic [SW-1:0] side_i;
    logic [XW-1:0] rem_x;
    logic [XW-1:0] den_x;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_i  = num_in;
      assign den_i  = den_in;
      assign quo_i  = '0;
      assign side_i = side_in;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign den_i  = den_r[k-1];
      assign quo_i  = quo_r[k-1];
      assign side_i = side_r[k-1];
    end

    // trial subtract of the shifted divisor
    assign rem_x = XW'(rem_i);
    assign den_x = XW'(den_i) << SH;
    assign take  = rem_x >= den_x;

    always_ff @(posedge clk) begin
      quo_r[k]  <= {quo_i[QW-2:0], take};
      side_r[k] <= side_i;
    end

    if (k < QW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem_r[k] <= take ? NW'(rem_x - den_x) : rem_i;
        den_r[k] <= den_i;
      end
    end
  end

  assign quo_out  = quo_r[QW-1];
  assign side_out = side_r[QW-1];
endmodule

FILE: hdl/sctt_front.sv
// ----------------------------------------------------------------------------
// sctt_front: request intake and count-to-millivolt conversion
// Scales both counts by full scale and pushes millivolt pairs to the queue.
// ----------------------------------------------------------------------------
module sctt_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sctt_pkg::in_item_t            in_data,
  input  logic [$clog2(sctt_pkg::QDEPTH+1)-1:0] q_count,
  output logic                          q_push,
  output sctt_pkg::mv_pair_t            q_wdata
);
  import sctt_pkg::*;

  localparam int PW  = COUNT_BITS + MV_W;
  localparam int FS  = (1 << COUNT_BITS) - 1;
  localparam int QCW = $clog2(QDEPTH + 1);

  logic          v1;
  logic [PW-1:0] prod_c;
  logic [PW-1:0] prod_t;
  logic          accept;

  // x / (2^n - 1) by folding the high part back twice and one correction
  function automatic logic [MV_W-1:0] div_fs(input logic [PW-1:0] p);
    logic [MV_W-1:0]       a;
    logic [COUNT_BITS:0]   s1;
    logic                  a2;
    logic [COUNT_BITS:0]   s2;
    logic                  c;
    a  = p[PW-1:COUNT_BITS];
    s1 = (COUNT_BITS+1)'(a) + (COUNT_BITS+1)'(p[COUNT_BITS-1:0]);
    a2 = s1[COUNT_BITS];
    s2 = (COUNT_BITS+1)'(a2) + (COUNT_BITS+1)'(s1[COUNT_BITS-1:0]);
    c  = s2 >= (COUNT_BITS+1)'(FS);
    return a + MV_W'(a2) + MV_W'(c);
  endfunction

  // room in the queue for everything already in flight
  assign in_ready = (QCW+1)'(q_count) + (QCW+1)'(v1) < (QCW+1)'(QDEPTH);
  assign accept   = in_valid && in_ready;

  // product stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= accept;
    end
    prod_c <= PW'(in_data.coolant_count) * PW'(MV_FULL);
    prod_t <= PW'(in_data.throttle_count) * PW'(MV_FULL);
  end

  // divide by full scale into the queue
  assign q_push      = v1;
  assign q_wdata.cmv = div_fs(prod_c);
  assign q_wdata.tmv = div_fs(prod_t);
endmodule

FILE: hdl/sctt_back.sv
// ----------------------------------------------------------------------------
// sctt_back: divider correction, table interpolation and throttle percent
// Fixed-latency pipeline, credit-controlled against the output fifo.
// ----------------------------------------------------------------------------
module sctt_back (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sctt_pkg::cfg_regs_t                   cfg,
  input  logic [$clog2(sctt_pkg::QDEPTH+1)-1:0] q_count,
  input  sctt_pkg::mv_pair_t                    q_rdata,
  output logic                                  q_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output sctt_pkg::out_item_t                   out_data
);
  import sctt_pkg::*;

  localparam int PRW  = MV_W + 8;
  localparam int S_QW = PRW;
  localparam int F_QW = 8;
  localparam int CNW  = SENS_W + 8;
  localparam int TNW  = SENS_W + 7;
  localparam int LAT  = 2 + S_QW + F_QW;
  localparam int OCW  = $clog2(ODEPTH + 1);
  localparam int CSW  = TEMP_W + 1 + 2 * MV_W;

  logic             pop_ok;
  logic [LAT-1:0]   vpipe;
  logic [OCW-1:0]   inflight;
  logic [OCW-1:0]   ocount;
  logic             owrite;
  logic             opop;
  out_item_t        owdata;

  logic [PRW-1:0]   b1_pc;
  logic [PRW-1:0]   b1_pt;
  logic [7:0]       b1_den;
  logic [MV_W-1:0]  b1_cmv;
  logic [MV_W-1:0]  b1_tmv;

  logic [S_QW-1:0]  s_qc;
  logic [S_QW-1:0]  s_qt;
  logic [MV_W-1:0]  s_cmv;
  logic [MV_W-1:0]  s_tmv;
  logic [SENS_W-1:0] sc;
  logic [SENS_W-1:0] st;

  logic [TEMP_W-1:0] c_base, c_base_r;
  logic              c_neg, c_neg_r;
  logic [CNW-1:0]    c_dvd, c_dvd_r;
  logic [SENS_W-1:0] c_dvs, c_dvs_r;
  logic [PCT_W-1:0]  t_base, t_base_r;
  logic [TNW-1:0]    t_dvd, t_dvd_r;
  logic [SENS_W-1:0] t_dvs, t_dvs_r;
  logic [MV_W-1:0]   f_cmv, f_tmv;

  logic [F_QW-1:0]   qc;
  logic [F_QW-1:0]   qt;
  logic [CSW-1:0]    c_side;
  logic [TEMP_W-1:0] e_base;
  logic              e_neg;
  logic [MV_W-1:0]   e_cmv, e_tmv;
  logic [PCT_W-1:0]  e_tbase;
  logic signed [TEMP_W+1:0] temp_sum;

  // issue when an output slot is reserved for the request
  assign pop_ok = (OCW+1)'(inflight) + (OCW+1)'(ocount) < (OCW+1)'(ODEPTH);
  assign q_pop  = (q_count != '0) && pop_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe    <= '0;
      inflight <= '0;
    end else begin
      vpipe    <= {vpipe[LAT-2:0], q_pop};
      inflight <= inflight + OCW'(q_pop) - OCW'(owrite);
    end
  end

  // divider ratio products
  always_ff @(posedge clk) begin
    b1_pc  <= PRW'(q_rdata.cmv) * PRW'(cfg.div_num);
    b1_pt  <= PRW'(q_rdata.tmv) * PRW'(cfg.div_num);
    b1_den <= (cfg.div_den == 8'd0) ? 8'd1 : cfg.div_den;
    b1_cmv <= q_rdata.cmv;
    b1_tmv <= q_rdata.tmv;
  end

  sctt_div #(.NW(PRW), .DW(8), .QW(S_QW), .SW(MV_W)) u_div_sc (
    .clk(clk), .num_in(b1_pc), .den_in(b1_den), .side_in(b1_cmv),
    .quo_out(s_qc), .side_out(s_cmv)
  );

  sctt_div #(.NW(PRW), .DW(8), .QW(S_QW), .SW(MV_W)) u_div_st (
    .clk(clk), .num_in(b1_pt), .den_in(b1_den), .side_in(b1_tmv),
    .quo_out(s_qt), .side_out(s_tmv)
  );

  // sensor-side saturation
  assign sc = (s_qc > S_QW'(SENS_MAX)) ? SENS_W'(SENS_MAX) : s_qc[SENS_W-1:0];
  assign st = (s_qt > S_QW'(SENS_MAX)) ? SENS_W'(SENS_MAX) : s_qt[SENS_W-1:0];

  // coolant segment select and interpolation setup
  always_comb begin
    logic              found;
    logic signed [TEMP_W:0] dt;
    logic [TEMP_W:0]   mag;
    logic [SENS_W-1:0] dv;
    logic [SENS_W-1:0] off;
    found  = 1'b0;
    c_base = TBL_TEMP[TABLE_POINTS-1];
    c_neg  = 1'b0;
    c_dvd  = '0;
    c_dvs  = SENS_W'(1);
    dt     = '0;
    mag    = '0;
    dv     = '0;
    off    = '0;
    if (sc >= TBL_MV[0]) begin
      c_base = TBL_TEMP[0];
    end else if (sc <= TBL_MV[TABLE_POINTS-1]) begin
      c_base = TBL_TEMP[TABLE_POINTS-1];
    end else begin
      for (int i = 0; i < TABLE_POINTS - 1; i++) begin
        if (!found && sc <= TBL_MV[i] && sc >= TBL_MV[i+1]) begin
          found  = 1'b1;
          dv     = TBL_MV[i] - TBL_MV[i+1];
          dt     = (TEMP_W+1)'(TBL_TEMP[i+1]) - (TEMP_W+1)'(TBL_TEMP[i]);
          mag    = dt[TEMP_W] ? (TEMP_W+1)'(-dt) : dt;
          off    = TBL_MV[i] - sc;
          c_base = TBL_TEMP[i];
          c_neg  = dt[TEMP_W];
          if (dv != '0) begin
            c_dvd = CNW'(off) * CNW'(mag[TEMP_W-1:0]);
            c_dvs = dv;
          end
        end
      end
    end
  end

  // throttle region select
  always_comb begin
    t_base = '0;
    t_dvd  = '0;
    t_dvs  = SENS_W'(1);
    if (st <= cfg.thr_closed) begin
      t_base = '0;
    end else if (st >= cfg.thr_open) begin
      t_base = PCT_W'(PCT_FULL);
    end else begin
      t_dvd = TNW'(st - cfg.thr_closed) * TNW'(PCT_FULL);
      t_dvs = cfg.thr_open - cfg.thr_closed;
    end
  end

  always_ff @(posedge clk) begin
    c_base_r <= c_base;
    c_neg_r  <= c_neg;
    c_dvd_r  <= c_dvd;
    c_dvs_r  <= c_dvs;
    t_base_r <= t_base;
    t_dvd_r  <= t_dvd;
    t_dvs_r  <= t_dvs;
    f_cmv    <= s_cmv;
    f_tmv    <= s_tmv;
  end

  sctt_div #(.NW(CNW), .DW(SENS_W), .QW(F_QW), .SW(CSW)) u_div_c (
    .clk(clk), .num_in(c_dvd_r), .den_in(c_dvs_r),
    .side_in({c_base_r, c_neg_r, f_cmv, f_tmv}),
    .quo_out(qc), .side_out(c_side)
  );

  sctt_div #(.NW(TNW), .DW(SENS_W), .QW(F_QW), .SW(PCT_W)) u_div_t (
    .clk(clk), .num_in(t_dvd_r), .den_in(t_dvs_r), .side_in(t_base_r),
    .quo_out(qt), .side_out(e_tbase)
  );

  // final sums
  assign {e_base, e_neg, e_cmv, e_tmv} = c_side;
  assign temp_sum = (TEMP_W+2)'($signed(e_base))
                  + (e_neg ? -$signed({2'b00, qc}) : $signed({2'b00, qc}));

  assign owrite                  = vpipe[LAT-1];
  assign owdata.coolant_celsius  = temp_sum[TEMP_W-1:0];
  assign owdata.throttle_percent = e_tbase + qt[PCT_W-1:0];
  assign owdata.coolant_adc_mv   = e_cmv;
  assign owdata.throttle_adc_mv  = e_tmv;

  // result skid fifo
  assign out_valid = ocount != '0;
  assign opop      = out_valid && out_ready;

  sctt_fifo #(.W($bits(out_item_t)), .DEPTH(ODEPTH)) u_ofifo (
    .clk(clk), .rst(rst), .push(owrite), .wdata(owdata),
    .pop(opop), .rdata(out_data), .count(ocount)
  );

  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    (OCW+1)'(inflight) + (OCW+1)'(ocount) <= (OCW+1)'(ODEPTH))
    else $error("in-flight requests exceed output fifo room");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    owrite |-> (ocount != OCW'(ODEPTH)) || opop)
    else $error("result written into full output fifo");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_count != '0)
    else $error("pop from empty queue");

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    owrite |-> owdata.throttle_percent <= PCT_W'(PCT_FULL))
    else $error("throttle percent above full scale");
endmodule

FILE: test/sensor_counts_to_temp_and_throttle_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sensor_counts_to_temp_and_throttle_test: self-checking bench
// Drives coolant/throttle count pairs through several divider and throttle
// settings, predicts temperature, percent and millivolts per request, and
// checks every result in order against the scoreboard.
// ----------------------------------------------------------------------------
module sensor_counts_to_temp_and_throttle_test;
  import sctt_pkg::*;

  localparam int LATENCY     = 32;
  localparam int STALL_LIMIT = 20000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd7;

  // divider and throttle settings used for prediction, pending results and checks
  class sensor_scoreboard;
    int unsigned ratio_num = 1;
    int unsigned ratio_den = 1;
    int unsigned closed_mv = 0;
    int unsigned open_mv   = 2250;
    out_item_t   pending[$];
    int          errors    = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_DIV_NUM:    ratio_num = val[7:0];
        REG_DIV_DEN:    ratio_den = val[7:0];
        REG_THR_CLOSED: closed_mv = val[SENS_W-1:0];
        REG_THR_OPEN:   open_mv   = val[SENS_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned to_mv(logic [COUNT_BITS-1:0] cnt);
      return (int'(cnt) * MV_FULL) / ((1 << COUNT_BITS) - 1);
    endfunction

    function int unsigned scale_mv(int unsigned mv);
      int unsigned s;
      s = (mv * ratio_num) / (ratio_den == 0 ? 1 : ratio_den);
      return s > SENS_MAX ? SENS_MAX : s;
    endfunction

    function int coolant_deg(int unsigned mv);
      int i;
      int dv;
      if (mv >= TBL_MV[0]) return TBL_TEMP[0];
      if (mv <= TBL_MV[TABLE_POINTS-1]) return TBL_TEMP[TABLE_POINTS-1];
      for (i = 0; i < TABLE_POINTS-1; i++) begin
        if (mv <= TBL_MV[i] && mv >= TBL_MV[i+1]) begin
          dv = int'(TBL_MV[i]) - int'(TBL_MV[i+1]);
          if (dv == 0) return TBL_TEMP[i];
          return int'(TBL_TEMP[i]) +
                 ((int'(TBL_MV[i]) - int'(mv)) * (int'(TBL_TEMP[i+1]) - int'(TBL_TEMP[i])))
                 / dv;
        end
      end
      return TBL_TEMP[TABLE_POINTS-1];
    endfunction

    function int unsigned throttle_pct(int unsigned mv);
      if (mv <= closed_mv) return 0;
      if (mv >= open_mv) return PCT_FULL;
      return ((mv - closed_mv) * PCT_FULL) / (open_mv - closed_mv);
    endfunction

    // note an accepted request
    function void note_request(in_item_t req);
      out_item_t r;
      int unsigned cmv;
      int unsigned tmv;
      int deg;
      cmv = to_mv(req.coolant_count);
      tmv = to_mv(req.throttle_count);
      deg = coolant_deg(scale_mv(cmv));
      r.coolant_celsius  = deg[TEMP_W-1:0];
      r.throttle_percent = PCT_W'(throttle_pct(scale_mv(tmv)));
      r.coolant_adc_mv   = MV_W'(cmv);
      r.throttle_adc_mv  = MV_W'(tmv);
      pending.push_back(r);
    endfunction

    // check an accepted result against the oldest prediction
    function void check_result(out_item_t got);
      out_item_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.coolant_celsius !== want.coolant_celsius) begin
        $display("%0t: coolant_celsius expected %0d actual %0d", $time,
                 want.coolant_celsius, got.coolant_celsius);
        errors++;
      end
      if (got.throttle_percent !== want.throttle_percent) begin
        $display("%0t: throttle_percent expected %0d actual %0d", $time,
                 want.throttle_percent, got.throttle_percent);
        errors++;
      end
      if (got.coolant_adc_mv !== want.coolant_adc_mv) begin
        $display("%0t: coolant_adc_mv expected %0d actual %0d", $time,
                 want.coolant_adc_mv, got.coolant_adc_mv);
        errors++;
      end
      if (got.throttle_adc_mv !== want.throttle_adc_mv) begin
        $display("%0t: throttle_adc_mv expected %0d actual %0d", $time,
                 want.throttle_adc_mv, got.throttle_adc_mv);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  sensor_scoreboard sb = new();
  bit rx_idle_on = 1'b1;
  bit rx_hold    = 1'b0;
  int idle_cycles = 0;

  sensor_counts_to_temp_and_throttle u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // request and result bookkeeping at each edge
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) sb.note_request(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: random stall bursts, or a long hold when asked
  initial begin : receiver
    int n;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (rx_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        rx_hold = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 16);
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_request(logic [COUNT_BITS-1:0] c, logic [COUNT_BITS-1:0] t, bit gaps);
    int n;
    if (gaps && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{coolant_count: c, throttle_count: t};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.set_reg(idx, val);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(int num, int den, int closed, int open);
    write_reg(REG_DIV_NUM, CFG_DATA_W'(num));
    write_reg(REG_DIV_DEN, CFG_DATA_W'(den));
    write_reg(REG_THR_CLOSED, CFG_DATA_W'(closed));
    write_reg(REG_THR_OPEN, CFG_DATA_W'(open));
  endtask

  // mostly counts, with a share at the ends of the range
  function automatic logic [COUNT_BITS-1:0] rand_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return COUNT_BITS'($urandom_range(0, 4095));
    endcase
  endfunction

  task automatic random_phase(int count, bit gaps);
    repeat (count) send_request(rand_count(), rand_count(), gaps);
  endtask

  initial begin : stimulus
    int k;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: count extremes and mid-range counts with reset settings
    send_request(12'd0, 12'd0, 1'b0);
    send_request(12'hfff, 12'hfff, 1'b0);
    send_request(12'd0, 12'hfff, 1'b0);
    send_request(12'hfff, 12'd0, 1'b0);
    send_request(12'd2792, 12'd2792, 1'b0);
    send_request(12'd373, 12'd1400, 1'b0);
    send_request(12'haaa, 12'h555, 1'b0);
    wait_drained();

    // zero numerator, zero denominator, unknown index, wide write
    set_config(0, 0, 16'hc000, 16'hffff);
    write_reg(REG_UNUSED, 16'h1234);
    send_request(12'hfff, 12'hfff, 1'b0);
    send_request(12'd1000, 12'd0, 1'b0);
    wait_drained();

    // large ratio saturates, open below closed
    set_config(255, 1, 3000, 1000);
    send_request(12'hfff, 12'hfff, 1'b0);
    send_request(12'd5, 12'd1, 1'b0);
    send_request(12'd0, 12'd0, 1'b0);
    wait_drained();

    // open equal to closed, ratio 1/255
    set_config(1, 255, 2000, 2000);
    send_request(12'hfff, 12'hfff, 1'b0);
    send_request(12'd0, 12'd0, 1'b0);
    wait_drained();

    // counts in steps of 700 with ratio 4/3
    set_config(4, 3, 16383, 16383);
    for (k = 0; k < 6; k++) send_request(COUNT_BITS'(k * 700), 12'hfff, 1'b0);
    wait_drained();

    // random phases across settings
    set_config(1, 1, 0, 2250);
    random_phase(250, 1'b1);

    // long receiver hold while sender keeps offering
    rx_hold = 1'b1;
    random_phase(100, 1'b0);
    wait_drained();

    set_config(2, 1, 500, 4500);
    random_phase(250, 1'b1);
    wait_drained();

    set_config(255, 255, 16383, 0);
    random_phase(150, 1'b1);
    wait_drained();

    set_config($urandom_range(1, 255), $urandom_range(1, 255),
               $urandom_range(0, 2000), $urandom_range(2000, 16383));
    random_phase(250, 1'b1);
    wait_drained();

    set_config(3, 2, 0, 16383);
    random_phase(250, 1'b1);
    wait_drained();

    // last part: no idling on either side
    set_config(5, 4, 300, 3000);
    rx_idle_on = 1'b0;
    random_phase(300, 1'b0);
    wait_drained();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/sctt_pkg.sv
hdl/sctt_fifo.sv
hdl/sctt_div.sv
hdl/sctt_front.sv
hdl/sctt_back.sv
hdl/sensor_counts_to_temp_and_throttle.sv
test/sensor_counts_to_temp_and_throttle_test.sv
